// ===== design/tea_block_cipher_macros.svh =====
// assertion macros for the tea block cipher
// each check is sampled on the rising edge of clk and is held off during reset
`ifndef TEA_BLOCK_CIPHER_MACROS_SVH
`define TEA_BLOCK_CIPHER_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define TEA_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tea_block_cipher: same-cycle check failed");

// next-cycle implication
`define TEA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tea_block_cipher: next-cycle check failed");

`else

`define TEA_ASSERT_IMPL(lbl, ante, cons)
`define TEA_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== design/tea_pkg.sv =====
`default_nettype none

package tea_pkg;

	localparam int WORD_W     = 32;
	localparam int ROUNDS     = 32;
	localparam int HALF_STEPS = 2 * ROUNDS;
	localparam int SHL        = 4;
	localparam int SHR        = 5;
	localparam int KEY_IDX_W  = 2;

	localparam logic [WORD_W-1:0] DELTA = 32'h9e37_79b9;

	// key register indexes
	localparam logic [KEY_IDX_W-1:0] KEY_A = 2'd0;
	localparam logic [KEY_IDX_W-1:0] KEY_B = 2'd1;
	localparam logic [KEY_IDX_W-1:0] KEY_C = 2'd2;
	localparam logic [KEY_IDX_W-1:0] KEY_D = 2'd3;

	// item modes
	localparam logic MODE_ENC = 1'b0;
	localparam logic MODE_DEC = 1'b1;

	typedef logic [WORD_W-1:0] word_t;

	// control travelling with each item down the pipeline
	typedef struct packed {
		logic valid;
		logic mode;
	} ctl_t;

	// round function
	function automatic word_t mix(input word_t a, input word_t s, input word_t p,
		input word_t q);
		word_t left;
		word_t mid;
		word_t right;
		left  = (a << SHL) + p;
		mid   = a + s;
		right = (a >> SHR) + q;
		return left ^ mid ^ right;
	endfunction

	// running sum used by half step h when encrypting
	function automatic word_t enc_sum(input int h);
		word_t rnd;
		rnd = WORD_W'((h >> 1) + 1);
		return WORD_W'(rnd * DELTA);
	endfunction

	// running sum used by half step h when decrypting
	function automatic word_t dec_sum(input int h);
		word_t rnd;
		rnd = WORD_W'(ROUNDS - (h >> 1));
		return WORD_W'(rnd * DELTA);
	endfunction

endpackage

`default_nettype wire

// ===== design/tea_stage.sv =====
`default_nettype none

// one half round of the cipher followed by its pipeline register
module tea_stage (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	input  wire logic            odd,
	input  wire tea_pkg::word_t  sum_enc,
	input  wire tea_pkg::word_t  sum_dec,
	input  wire tea_pkg::word_t  key_a,
	input  wire tea_pkg::word_t  key_b,
	input  wire tea_pkg::word_t  key_c,
	input  wire tea_pkg::word_t  key_d,
	input  wire tea_pkg::ctl_t   ctl_in,
	input  wire tea_pkg::word_t  y_in,
	input  wire tea_pkg::word_t  z_in,
	output tea_pkg::ctl_t        ctl_out,
	output tea_pkg::word_t       y_out,
	output tea_pkg::word_t       z_out
);

	logic           upd_y;
	tea_pkg::word_t src;
	tea_pkg::word_t dst;
	tea_pkg::word_t p;
	tea_pkg::word_t q;
	tea_pkg::word_t sum;
	tea_pkg::word_t f;
	tea_pkg::word_t upd;
	tea_pkg::ctl_t  ctl_q;
	tea_pkg::word_t y_q;
	tea_pkg::word_t z_q;

	// encryption updates y first, decryption updates z first
	assign upd_y = (ctl_in.mode == tea_pkg::MODE_DEC) ? odd : !odd;
	assign src   = upd_y ? z_in : y_in;
	assign dst   = upd_y ? y_in : z_in;
	assign p     = upd_y ? key_a : key_c;
	assign q     = upd_y ? key_b : key_d;
	assign sum   = (ctl_in.mode == tea_pkg::MODE_DEC) ? sum_dec : sum_enc;

	// mix and accumulate
	always_comb begin
		f = tea_pkg::mix(src, sum, p, q);
		if (ctl_in.mode == tea_pkg::MODE_DEC) begin
			upd = dst - f;
		end else begin
			upd = dst + f;
		end
	end

	// control register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (en) begin
			ctl_q <= ctl_in;
		end
	end

	// data register
	always_ff @(posedge clk) begin
		if (en) begin
			y_q <= upd_y ? upd : y_in;
			z_q <= upd_y ? z_in : upd;
		end
	end

	assign ctl_out = ctl_q;
	assign y_out   = y_q;
	assign z_out   = z_q;

endmodule

`default_nettype wire

// ===== design/tea_block_cipher.sv =====
`default_nettype none

// channel  | handshake              | payload
// in       | in_valid / in_ready    | mode, block_first, block_second
// out      | out_valid / out_ready  | result_first, result_second
// cfg      | cfg_we                 | cfg_idx, cfg_wdata
//
// 64 half-round stages; one item can be accepted every cycle while the pipeline is
// not holding.
// the whole pipeline advances together; it holds only when its last stage has an
// item and the two-entry output buffer is full, so in_ready comes from registers.
// arst_n clears the key registers, the stage valid bits and the output buffer.
`include "tea_block_cipher_macros.svh"

module tea_block_cipher (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [tea_pkg::KEY_IDX_W-1:0]   cfg_idx,
	input  wire logic [tea_pkg::WORD_W-1:0]      cfg_wdata,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic                            mode,
	input  wire logic [tea_pkg::WORD_W-1:0]      block_first,
	input  wire logic [tea_pkg::WORD_W-1:0]      block_second,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic [tea_pkg::WORD_W-1:0]           result_first,
	output logic [tea_pkg::WORD_W-1:0]           result_second
);

	localparam int NS = tea_pkg::HALF_STEPS;

	tea_pkg::word_t key_a_q;
	tea_pkg::word_t key_b_q;
	tea_pkg::word_t key_c_q;
	tea_pkg::word_t key_d_q;

	tea_pkg::ctl_t  ctl_s [0:NS];
	tea_pkg::word_t y_s   [0:NS];
	tea_pkg::word_t z_s   [0:NS];

	logic           en;
	logic           push;
	logic           pop;
	logic [1:0]     cnt_q;
	logic           wr_q;
	logic           rd_q;
	tea_pkg::word_t first_q  [0:1];
	tea_pkg::word_t second_q [0:1];

	// key registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_a_q <= '0;
			key_b_q <= '0;
			key_c_q <= '0;
			key_d_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				tea_pkg::KEY_A: key_a_q <= cfg_wdata;
				tea_pkg::KEY_B: key_b_q <= cfg_wdata;
				tea_pkg::KEY_C: key_c_q <= cfg_wdata;
				tea_pkg::KEY_D: key_d_q <= cfg_wdata;
				default:        key_a_q <= key_a_q;
			endcase
		end
	end

	// pipeline advance: hold only when a finished item has nowhere to go
	assign en       = !(ctl_s[NS].valid && (cnt_q == 2'd2));
	assign in_ready = en;

	// entry into the first stage
	assign ctl_s[0].valid = in_valid;
	assign ctl_s[0].mode  = mode;
	assign y_s[0]         = block_first;
	assign z_s[0]         = block_second;

	// half-round stages
	for (genvar h = 0; h < NS; h++) begin : g_stage
		tea_stage u_stage (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.odd     (1'(h % 2)),
			.sum_enc (tea_pkg::enc_sum(h)),
			.sum_dec (tea_pkg::dec_sum(h)),
			.key_a   (key_a_q),
			.key_b   (key_b_q),
			.key_c   (key_c_q),
			.key_d   (key_d_q),
			.ctl_in  (ctl_s[h]),
			.y_in    (y_s[h]),
			.z_in    (z_s[h]),
			.ctl_out (ctl_s[h+1]),
			.y_out   (y_s[h+1]),
			.z_out   (z_s[h+1])
		);
	end

	// output buffer control
	assign push = ctl_s[NS].valid && en;
	assign pop  = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// output buffer data
	always_ff @(posedge clk) begin
		if (push) begin
			first_q[wr_q]  <= y_s[NS];
			second_q[wr_q] <= z_s[NS];
		end
	end

	assign out_valid     = (cnt_q != 2'd0);
	assign result_first  = first_q[rd_q];
	assign result_second = second_q[rd_q];

	// checks
	`TEA_ASSERT_IMPL(a_cnt_range, 1'b1, cnt_q != 2'd3)
	`TEA_ASSERT_NEXT(a_accept_enters, in_valid && in_ready, ctl_s[1].valid)
	`TEA_ASSERT_NEXT(a_hold_last, !en, ctl_s[NS].valid && $stable(y_s[NS]))
	`TEA_ASSERT_NEXT(a_push_count, push && !pop, cnt_q == $past(cnt_q) + 2'd1)
	`TEA_ASSERT_IMPL(a_ptr_match, cnt_q == 2'd0 || cnt_q == 2'd2, wr_q == rd_q)

endmodule

`default_nettype wire
